@@ src/m2ds_pkg.sv @@
// Shared constants and types of the 2x2 median downscaler.
package m2ds_pkg;

	// Default depth of the line store in pixels.
	localparam int MAX_COLS_DEF = 4096;

	// Configuration register indexes.
	localparam logic [1:0] REG_IN_COLS = 2'd0;
	localparam logic [1:0] REG_IN_ROWS = 2'd1;
	localparam logic [1:0] REG_MODE    = 2'd2;

	// Output modes; any other code acts as the plain median.
	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_TEXT  = 2'd1;
	localparam logic [1:0] MODE_ROI   = 2'd2;

	localparam logic [7:0] WHITE         = 8'd255;
	localparam logic [7:0] ROI_MIN_LEVEL = 8'd1;

	// Access strobes for the line store.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ls_ctrl_t;

endpackage

@@ src/m2ds_line_store.sv @@
// Line store for the even input row, split into even-column and odd-column memories.
module m2ds_line_store #(
	parameter int MAX_COLS = m2ds_pkg::MAX_COLS_DEF,
	parameter int CW       = $clog2(MAX_COLS)
) (
	input  logic               clk,
	input  m2ds_pkg::ls_ctrl_t ctrl,
	input  logic [CW-1:0]      wr_col,
	input  logic [7:0]         wr_data,
	input  logic [CW-1:0]      rd_col,
	output logic [7:0]         rd_even,
	output logic [7:0]         rd_odd
);

	localparam int DEPTH = (MAX_COLS + 1) / 2;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Column pairs share one address: the even column in one memory, the odd in the other.
	logic [7:0]    even_mem [DEPTH];
	logic [7:0]    odd_mem  [DEPTH];
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign wr_addr = AW'(wr_col >> 1);
	assign rd_addr = AW'(rd_col >> 1);

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && !wr_col[0]) begin
			even_mem[wr_addr] <= wr_data;
		end
		if (ctrl.wr_en && wr_col[0]) begin
			odd_mem[wr_addr] <= wr_data;
		end
	end

	// Registered read data holds until the next read.
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_even <= even_mem[rd_addr];
			rd_odd  <= odd_mem[rd_addr];
		end
	end

endmodule

@@ src/median_2x2_downscaler.sv @@
// Top level of the 2x2 median downscaler: counters, line store control and output pipeline.
// Throughput: one input pixel per clock while the output side keeps up.
// A result reaches the master side through the line store read, the mean stage and the median
// stage after the transaction that delivers the lower right pixel of its block.
// Reset clears the counters, the pipeline valid bits and the registers to their defaults;
// the line store is not cleared and needs no clearing pass, so pixels are taken at once.
module median_2x2_downscaler #(
	parameter int MAX_COLS = m2ds_pkg::MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input pixel stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel
	// Output pixel stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_pixel
	output logic        m_tlast,   // row_end: last output pixel of an output row
	output logic        m_tuser,   // [0] frame_end: last output pixel of a frame
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW = $clog2(MAX_COLS);

	// Reset values of the configuration registers.
	localparam logic [12:0] IN_COLS_RST = 13'd640;
	localparam logic [15:0] IN_ROWS_RST = 16'd480;

	// Width clamped to the range 2 .. MAX_COLS.
	function automatic logic [31:0] eff_cols(input logic [12:0] v);
		logic [31:0] e;
		e = {19'b0, v};
		if (e < 32'd2) e = 32'd2;
		if (e > 32'(MAX_COLS)) e = 32'(MAX_COLS);
		return e;
	endfunction

	function automatic logic [CW-1:0] cols_m1_of(input logic [12:0] v);
		logic [31:0] e;
		e = eff_cols(v);
		return CW'(e - 32'd1);
	endfunction

	// Last column of the last complete block; an odd last column is dropped.
	function automatic logic [CW-1:0] last_col_of(input logic [12:0] v);
		logic [31:0] e;
		e = eff_cols(v);
		return CW'((e & ~32'd1) - 32'd1);
	endfunction

	function automatic logic [15:0] rows_m1_of(input logic [15:0] v);
		logic [15:0] e;
		e = (v < 16'd2) ? 16'd2 : v;
		return e - 16'd1;
	endfunction

	function automatic logic [15:0] last_row_of(input logic [15:0] v);
		logic [15:0] e;
		e = (v < 16'd2) ? 16'd2 : v;
		return (e & ~16'd1) - 16'd1;
	endfunction

	// Median of five values. The smaller of the two pair minimums can never be the
	// median, so it is dropped and the second smallest of the remaining four is taken.
	function automatic logic [7:0] median5(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d, input logic [7:0] e);
		logic [7:0] lo0, hi0, lo1, hi1, x, y, u, p, q;
		lo0 = (a < b) ? a : b;
		hi0 = (a < b) ? b : a;
		lo1 = (c < d) ? c : d;
		hi1 = (c < d) ? d : c;
		if (lo0 < lo1) begin
			x = lo1;
			y = hi1;
			u = hi0;
		end else begin
			x = lo0;
			y = hi0;
			u = hi1;
		end
		p = (u < e) ? u : e;
		q = (u < e) ? e : u;
		if (x <= p) begin
			return (y < p) ? y : p;
		end else begin
			return (x < q) ? x : q;
		end
	endfunction

	function automatic logic [7:0] max4(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d);
		logic [7:0] m0, m1;
		m0 = (a > b) ? a : b;
		m1 = (c > d) ? c : d;
		return (m0 > m1) ? m0 : m1;
	endfunction

	// Configuration, kept in the derived form that the counters compare against.
	logic [CW-1:0] cols_m1_q;
	logic [CW-1:0] last_col_q;
	logic [15:0]   rows_m1_q;
	logic [15:0]   last_row_q;
	logic [1:0]    mode_q;

	// Position of the next input pixel and the left pixel of the current odd-row block.
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	logic [7:0]    left_q;

	// Pipeline: s1 holds the line store read, s2 the four pixels and their mean.
	logic          v_s1;
	logic [7:0]    left_s1;
	logic [7:0]    px_s1;
	logic          row_end_s1;
	logic          frame_end_s1;
	logic          v_s2;
	logic [7:0]    up_l_s2;
	logic [7:0]    left_s2;
	logic [7:0]    up_r_s2;
	logic [7:0]    px_s2;
	logic [7:0]    mean_s2;
	logic          row_end_s2;
	logic          frame_end_s2;
	logic          out_v_q;
	logic [7:0]    out_pixel_q;
	logic          row_end_q;
	logic          frame_end_q;

	logic               out_en;
	logic               en_s2;
	logic               en_s1;
	logic               accept;
	logic               rd_fire;
	logic               row_end_c;
	m2ds_pkg::ls_ctrl_t ls_ctrl;
	logic [7:0]         up_l_s1;
	logic [7:0]         up_r_s1;
	logic [9:0]         sum_s1;
	logic [7:0]         med_s2;
	logic [7:0]         max_s2;
	logic [7:0]         result_s2;

	// Each stage moves when it is empty or the stage after it moves, so empty slots
	// collapse and input keeps flowing while a result waits at the output.
	assign out_en   = !out_v_q || m_tready;
	assign en_s2    = !v_s2 || out_en;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign accept   = s_tvalid && s_tready;

	assign cfg_ready = 1'b1;

	// A block completes on an odd column of an odd row, unless it is a dropped odd column.
	assign rd_fire   = accept && row_q[0] && col_q[0] && (col_q <= last_col_q);
	assign row_end_c = (col_q == last_col_q);

	// Even rows fill the line store; only columns inside the width are written.
	assign ls_ctrl = '{
		wr_en: accept && !row_q[0] && (col_q <= cols_m1_q),
		rd_en: rd_fire && en_s1
	};

	m2ds_line_store #(
		.MAX_COLS (MAX_COLS),
		.CW       (CW)
	) u_line_store (
		.clk     (clk),
		.ctrl    (ls_ctrl),
		.wr_col  (col_q),
		.wr_data (s_tdata),
		.rd_col  (col_q),
		.rd_even (up_l_s1),
		.rd_odd  (up_r_s1)
	);

	// Rounded mean of the block.
	assign sum_s1 = 10'(up_l_s1) + 10'(left_s1) + 10'(up_r_s1) + 10'(px_s1) + 10'd2;

	always_comb begin
		med_s2    = median5(up_l_s2, left_s2, up_r_s2, px_s2, mean_s2);
		max_s2    = max4(up_l_s2, left_s2, up_r_s2, px_s2);
		result_s2 = med_s2;
		// Text mode keeps white strokes white.
		if (mode_q == m2ds_pkg::MODE_TEXT && max_s2 == m2ds_pkg::WHITE) begin
			result_s2 = m2ds_pkg::WHITE;
		end
		// ROI mode never turns a block with any light pixel fully black.
		if (mode_q == m2ds_pkg::MODE_ROI && med_s2 == 8'd0 && max_s2 != 8'd0) begin
			result_s2 = m2ds_pkg::ROI_MIN_LEVEL;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_m1_q  <= cols_m1_of(IN_COLS_RST);
			last_col_q <= last_col_of(IN_COLS_RST);
			rows_m1_q  <= rows_m1_of(IN_ROWS_RST);
			last_row_q <= last_row_of(IN_ROWS_RST);
			mode_q     <= m2ds_pkg::MODE_PLAIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				m2ds_pkg::REG_IN_COLS: begin
					cols_m1_q  <= cols_m1_of(cfg_data[12:0]);
					last_col_q <= last_col_of(cfg_data[12:0]);
				end
				m2ds_pkg::REG_IN_ROWS: begin
					rows_m1_q  <= rows_m1_of(cfg_data);
					last_row_q <= last_row_of(cfg_data);
				end
				m2ds_pkg::REG_MODE: begin
					mode_q <= cfg_data[1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Raster counters. A counter left past the end by a configuration change wraps
	// at the next pixel, exactly as at the last position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			if (row_q[0] && !col_q[0]) begin
				left_q <= s_tdata;
			end
			if (col_q >= cols_m1_q) begin
				col_q <= '0;
				row_q <= (row_q >= rows_m1_q) ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= rd_fire;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (out_en) begin
				out_v_q <= v_s2;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (en_s1 && rd_fire) begin
			left_s1      <= left_q;
			px_s1        <= s_tdata;
			row_end_s1   <= row_end_c;
			frame_end_s1 <= row_end_c && (row_q == last_row_q);
		end
		if (en_s2 && v_s1) begin
			up_l_s2      <= up_l_s1;
			left_s2      <= left_s1;
			up_r_s2      <= up_r_s1;
			px_s2        <= px_s1;
			mean_s2      <= sum_s1[9:2];
			row_end_s2   <= row_end_s1;
			frame_end_s2 <= frame_end_s1;
		end
		if (out_en && v_s2) begin
			out_pixel_q <= result_s2;
			row_end_q   <= row_end_s2;
			frame_end_q <= frame_end_s2;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_pixel_q;
	assign m_tlast  = row_end_q;
	assign m_tuser  = frame_end_q;

endmodule
